>>> design/hsvrgb_pkg.sv
`default_nettype none

package hsvrgb_pkg;

   // default number of fraction bits (Q1.12)
   localparam int FRAC_BITS_DEF = 12;

   // hue sector codes after the multiply by six
   localparam logic [2:0] SECTOR_0 = 3'd0;
   localparam logic [2:0] SECTOR_1 = 3'd1;
   localparam logic [2:0] SECTOR_2 = 3'd2;
   localparam logic [2:0] SECTOR_3 = 3'd3;
   localparam logic [2:0] SECTOR_4 = 3'd4;
   localparam logic [2:0] SECTOR_5 = 3'd5;
   localparam logic [2:0] SECTOR_6 = 3'd6;

endpackage

`default_nettype wire

>>> design/hsv_to_rgb_converter_unit.sv
`default_nettype none
// HSV to RGB converter, Q1.FRAC_BITS fixed point, four register stages.
// An accepted request beat passes through stages 1, 2, 3 and the output register.
// One beat per cycle while not stalled; each stage holds one beat and moves on
// when the stage ahead is empty or moving, so stalls only fill the bubbles.
// Reset (synchronous, active high) clears every stage valid bit.

module hsv_to_rgb_converter_unit
   import hsvrgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [FRAC_BITS:0] req_hue,
   input  wire logic [FRAC_BITS:0] req_saturation,
   input  wire logic [FRAC_BITS:0] req_brightness,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [FRAC_BITS:0] rsp_red_out,
   output logic      [FRAC_BITS:0] rsp_green_out,
   output logic      [FRAC_BITS:0] rsp_blue_out
);

   localparam int W = FRAC_BITS + 1;
   localparam int PW = 2 * W;
   localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // stage valid bits and load enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic load1, load2, load3, load4;

   assign load4 = !rsp_valid_ff || !rsp_stall;
   assign load3 = !s3_valid_ff || load4;
   assign load2 = !s2_valid_ff || load3;
   assign load1 = !s1_valid_ff || load2;

   assign req_stall = !load1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load1) s1_valid_ff  <= req_valid;
         if (load2) s2_valid_ff  <= s1_valid_ff;
         if (load3) s3_valid_ff  <= s2_valid_ff;
         if (load4) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------- stage 1: clamp, hue times six ----------------
   logic [W-1:0]         hue_sat, sat_sat, bri_sat;
   logic [FRAC_BITS+2:0] hue6;
   logic [2:0]           s1_sector_ff, s1_sector_in;
   logic [FRAC_BITS-1:0] s1_frac_ff, s1_frac_in;
   logic [W-1:0]         s1_sat_ff, s1_bri_ff;

   assign hue_sat = (req_hue > ONE) ? ONE : req_hue;
   assign sat_sat = (req_saturation > ONE) ? ONE : req_saturation;
   assign bri_sat = (req_brightness > ONE) ? ONE : req_brightness;

   // 6h = 4h + 2h
   assign hue6 = {hue_sat, 2'b00} + {1'b0, hue_sat, 1'b0};
   assign s1_sector_in = hue6[FRAC_BITS +: 3];
   assign s1_frac_in   = hue6[FRAC_BITS-1:0];

   always_ff @(posedge clock) begin
      if (load1) begin
         s1_sector_ff <= s1_sector_in;
         s1_frac_ff   <= s1_frac_in;
         s1_sat_ff    <= sat_sat;
         s1_bri_ff    <= bri_sat;
      end
   end

   // ---------------- stage 2: 1-s, 1-s*f, 1-s*(1-f) ----------------
   logic [W-1:0]  one_minus_f;
   logic [PW-1:0] prod_sf, prod_s1f;
   logic [2:0]    s2_sector_ff;
   logic          s2_gray_ff, s2_gray_in;
   logic [W-1:0]  s2_bri_ff;
   logic [W-1:0]  s2_oms_ff, s2_oms_in;
   logic [W-1:0]  s2_omsf_ff, s2_omsf_in;
   logic [W-1:0]  s2_oms1f_ff, s2_oms1f_in;

   assign one_minus_f = ONE - {1'b0, s1_frac_ff};
   assign prod_sf     = PW'(s1_sat_ff) * PW'(s1_frac_ff);
   assign prod_s1f    = PW'(s1_sat_ff) * PW'(one_minus_f);
   assign s2_gray_in  = (s1_sat_ff == '0);
   assign s2_oms_in   = ONE - s1_sat_ff;
   assign s2_omsf_in  = ONE - prod_sf[FRAC_BITS +: W];
   assign s2_oms1f_in = ONE - prod_s1f[FRAC_BITS +: W];

   always_ff @(posedge clock) begin
      if (load2) begin
         s2_sector_ff <= s1_sector_ff;
         s2_gray_ff   <= s2_gray_in;
         s2_bri_ff    <= s1_bri_ff;
         s2_oms_ff    <= s2_oms_in;
         s2_omsf_ff   <= s2_omsf_in;
         s2_oms1f_ff  <= s2_oms1f_in;
      end
   end

   // ---------------- stage 3: products with brightness ----------------
   logic [PW-1:0] prod_a, prod_b, prod_c;
   logic [2:0]    s3_sector_ff;
   logic          s3_gray_ff;
   logic [W-1:0]  s3_bri_ff, s3_pa_ff, s3_pb_ff, s3_pc_ff;

   assign prod_a = PW'(s2_bri_ff) * PW'(s2_oms_ff);
   assign prod_b = PW'(s2_bri_ff) * PW'(s2_omsf_ff);
   assign prod_c = PW'(s2_bri_ff) * PW'(s2_oms1f_ff);

   always_ff @(posedge clock) begin
      if (load3) begin
         s3_sector_ff <= s2_sector_ff;
         s3_gray_ff   <= s2_gray_ff;
         s3_bri_ff    <= s2_bri_ff;
         s3_pa_ff     <= prod_a[FRAC_BITS +: W];
         s3_pb_ff     <= prod_b[FRAC_BITS +: W];
         s3_pc_ff     <= prod_c[FRAC_BITS +: W];
      end
   end

   // ---------------- stage 4: sector routing, output register ----------------
   logic [W-1:0] red_in, green_in, blue_in;
   logic [W-1:0] red_ff, green_ff, blue_ff;

   hsvrgb_sector_mux #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mux (
      .sector (s3_sector_ff),
      .gray   (s3_gray_ff),
      .bri    (s3_bri_ff),
      .pa     (s3_pa_ff),
      .pb     (s3_pb_ff),
      .pc     (s3_pc_ff),
      .red    (red_in),
      .green  (green_in),
      .blue   (blue_in)
   );

   always_ff @(posedge clock) begin
      if (load4) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;

endmodule

`default_nettype wire

>>> design/hsvrgb_sector_mux.sv
`default_nettype none

module hsvrgb_sector_mux
   import hsvrgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic [2:0]         sector,
   input  wire logic               gray,
   input  wire logic [FRAC_BITS:0] bri,
   input  wire logic [FRAC_BITS:0] pa,
   input  wire logic [FRAC_BITS:0] pb,
   input  wire logic [FRAC_BITS:0] pc,
   output logic      [FRAC_BITS:0] red,
   output logic      [FRAC_BITS:0] green,
   output logic      [FRAC_BITS:0] blue
);

   // route brightness and the three products by hue sector
   always_comb begin
      red   = bri;
      green = pc;
      blue  = pa;
      if (gray) begin
         red   = bri;
         green = bri;
         blue  = bri;
      end else begin
         case (sector)
            SECTOR_1: begin
               red = pb; green = bri; blue = pa;
            end
            SECTOR_2: begin
               red = pa; green = bri; blue = pc;
            end
            SECTOR_3: begin
               red = pa; green = pb; blue = bri;
            end
            SECTOR_4: begin
               red = pc; green = pa; blue = bri;
            end
            SECTOR_5: begin
               red = bri; green = pa; blue = pb;
            end
            // sector 0 and full hue (sector 6) share one colour
            default: begin
               red = bri; green = pc; blue = pa;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

>>> design/hsvrgb_checker.sv
`default_nettype none

module hsvrgb_checker
   import hsvrgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic [FRAC_BITS:0] rsp_red_out,
   input wire logic [FRAC_BITS:0] rsp_green_out,
   input wire logic [FRAC_BITS:0] rsp_blue_out
);

   localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // a stalled response beat stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // a stalled response beat keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         $stable(rsp_red_out) && $stable(rsp_green_out) && $stable(rsp_blue_out))
      else $error("response payload changed while stalled");

   // channels never exceed full intensity
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_out <= ONE && rsp_green_out <= ONE && rsp_blue_out <= ONE)
      else $error("channel above full scale");

   // the pipeline is empty on the first cycle out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid straight after reset");

   // with the output side and the request input idle, requests are never held off
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && $past(!rsp_valid, 2) && $past(!rsp_valid, 3)
         && !$past(req_valid) && !$past(req_valid, 2) && !$past(req_valid, 3)
         |-> !req_stall)
      else $error("request stalled with pipeline empty");

endmodule

bind hsv_to_rgb_converter_unit hsvrgb_checker #(
   .FRAC_BITS (FRAC_BITS)
) u_hsvrgb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out)
);

`default_nettype wire

>>> tb/tb_hsv_to_rgb_converter_unit.sv
module tb_hsv_to_rgb_converter_unit;
   import hsvrgb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB          = FRAC_BITS_DEF;
   localparam int ONE         = 1 << FB;
   localparam int FIELD_MAX   = (1 << (FB + 1)) - 1;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_PAD   = 12;
   localparam int MAX_PRINTS  = 50;

   typedef logic [FB:0] field_t;

   typedef struct packed {
      field_t red;
      field_t green;
      field_t blue;
   } rgb_t;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_stall;
   field_t req_hue = '0;
   field_t req_saturation = '0;
   field_t req_brightness = '0;
   logic   rsp_valid;
   logic   rsp_stall = 1'b0;
   field_t rsp_red_out;
   field_t rsp_green_out;
   field_t rsp_blue_out;

   // expected pixels, oldest first
   rgb_t expected_rgb[$];

   int pixels_sent    = 0;
   int pixels_checked = 0;
   int input_stalls   = 0;
   int errors         = 0;

   // idle rates in percent, set per phase
   int send_idle_pct = 0;
   int stall_pct     = 0;

   // long output hold-off, requested by bumping hold_asked
   int hold_asked = 0;
   int hold_taken = 0;
   int hold_left  = 0;

   hsv_to_rgb_converter_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red_out    (rsp_red_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_blue_out   (rsp_blue_out)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // clamp anything above one to one
   function automatic longint unsigned clamp_one(field_t x);
      return (x > ONE) ? ONE : longint'(x);
   endfunction

   // HSV to RGB in Q1.FB, every product truncated
   function automatic rgb_t predict_rgb(field_t hue, field_t sat, field_t bri);
      longint unsigned h, s, v, h6, f, pa, pb, pc;
      logic [2:0]      sector;
      rgb_t            px;
      h = clamp_one(hue);
      s = clamp_one(sat);
      v = clamp_one(bri);
      if (s == 0) begin
         px.red   = field_t'(v);
         px.green = field_t'(v);
         px.blue  = field_t'(v);
         return px;
      end
      h6     = h * 6;
      sector = 3'(h6 >> FB);
      f      = h6 & (ONE - 1);
      pa     = (v * (ONE - s)) >> FB;
      pb     = (v * (ONE - ((s * f) >> FB))) >> FB;
      pc     = (v * (ONE - ((s * (ONE - f)) >> FB))) >> FB;
      case (sector)
         SECTOR_1: begin
            px.red = field_t'(pb); px.green = field_t'(v);  px.blue = field_t'(pa);
         end
         SECTOR_2: begin
            px.red = field_t'(pa); px.green = field_t'(v);  px.blue = field_t'(pc);
         end
         SECTOR_3: begin
            px.red = field_t'(pa); px.green = field_t'(pb); px.blue = field_t'(v);
         end
         SECTOR_4: begin
            px.red = field_t'(pc); px.green = field_t'(pa); px.blue = field_t'(v);
         end
         SECTOR_5: begin
            px.red = field_t'(v);  px.green = field_t'(pa); px.blue = field_t'(pb);
         end
         // sector 0, and full hue wrapping round as sector 6
         default: begin
            px.red = field_t'(v);  px.green = field_t'(pc); px.blue = field_t'(pa);
         end
      endcase
      return px;
   endfunction

   task automatic report_mismatch(string msg);
      if (errors < MAX_PRINTS)
         $display("[%0t] ERROR %s", $realtime, msg);
      errors++;
   endtask

   // one request beat; valid stays high unless a gap is rolled
   task automatic send_pixel(field_t hue, field_t sat, field_t bri);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid      <= 1'b0;
         req_hue        <= field_t'($urandom);
         req_saturation <= field_t'($urandom);
         req_brightness <= field_t'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      do @(posedge clock); while (req_stall);
      expected_rgb.push_back(predict_rgb(hue, sat, bri));
      pixels_sent++;
   endtask

   // random field, biased towards zero, one and over-range
   function automatic field_t rand_field();
      case ($urandom_range(15))
         0:       return '0;
         1:       return field_t'(ONE);
         2, 3:    return field_t'($urandom_range(FIELD_MAX));
         default: return field_t'($urandom_range(ONE));
      endcase
   endfunction

   task automatic run_random(int count);
      repeat (count) send_pixel(rand_field(), rand_field(), rand_field());
   endtask

   // output stall driver, with the long hold-off counted here
   always @(posedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken <= hold_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
      end
   end

   // response checker
   always @(posedge clock) begin
      rgb_t want;
      if (!reset) begin
         if (req_valid && req_stall)
            input_stalls++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb.size() == 0) begin
               report_mismatch($sformatf("unexpected beat r=%0d g=%0d b=%0d",
                                         rsp_red_out, rsp_green_out, rsp_blue_out));
            end else begin
               want = expected_rgb.pop_front();
               if (rsp_red_out !== want.red)
                  report_mismatch($sformatf("pixel %0d red %0d, want %0d",
                                            pixels_checked, rsp_red_out, want.red));
               if (rsp_green_out !== want.green)
                  report_mismatch($sformatf("pixel %0d green %0d, want %0d",
                                            pixels_checked, rsp_green_out, want.green));
               if (rsp_blue_out !== want.blue)
                  report_mismatch($sformatf("pixel %0d blue %0d, want %0d",
                                            pixels_checked, rsp_blue_out, want.blue));
            end
            pixels_checked++;
         end
      end
   end

   // gray, saturated inputs and the ends of each field
   task automatic test_gray_and_extremes();
      send_pixel(1234, 0, field_t'(ONE));
      send_pixel(0, 0, 0);
      send_pixel(field_t'(ONE), 0, 2500);
      send_pixel(field_t'(FIELD_MAX), 0, field_t'(FIELD_MAX));
      send_pixel(0, field_t'(ONE), field_t'(ONE));
      send_pixel(field_t'(ONE), field_t'(ONE), field_t'(ONE));
      send_pixel(field_t'(FIELD_MAX), field_t'(FIELD_MAX), field_t'(FIELD_MAX));
      send_pixel(field_t'(ONE + 1), 5000, 6000);
      send_pixel(0, 1, field_t'(ONE));
      send_pixel(field_t'(ONE), 1, 1);
      send_pixel(2048, field_t'(ONE), 0);
      send_pixel(field_t'(ONE - 1), field_t'(ONE), field_t'(ONE));
   endtask

   // middle of every sector, plus both sides of the first boundary
   task automatic test_sectors();
      for (int k = 0; k < 6; k++)
         send_pixel(field_t'((2 * k + 1) * ONE / 12), 3000, 4000);
      send_pixel(field_t'(ONE / 6), field_t'(ONE), field_t'(ONE));
      send_pixel(field_t'(ONE / 6 + 1), field_t'(ONE), field_t'(ONE));
   endtask

   task automatic test_random_streaming();
      send_idle_pct = 0;
      stall_pct     = 0;
      run_random(250);
   endtask

   task automatic test_random_sender_idle();
      send_idle_pct = 82;
      stall_pct     = 0;
      run_random(250);
   endtask

   task automatic test_random_receiver_stall();
      send_idle_pct = 0;
      stall_pct     = 82;
      run_random(250);
   endtask

   task automatic test_random_both_idle();
      send_idle_pct = 35;
      stall_pct     = 35;
      run_random(250);
   endtask

   // output held off for a long stretch while requests keep coming
   task automatic test_back_pressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_asked   <= hold_asked + 1;
      run_random(40);
   endtask

   initial begin
      #5_000_000;
      $display("hsv_to_rgb_converter_unit: mismatch");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_gray_and_extremes();
      test_sectors();
      test_random_streaming();
      test_back_pressure();
      test_random_sender_idle();
      test_random_receiver_stall();
      test_random_both_idle();

      req_valid <= 1'b0;
      stall_pct  = 0;
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (DRAIN_PAD) @(posedge clock);
      if (expected_rgb.size() != 0)
         report_mismatch($sformatf("%0d pixels never came out", expected_rgb.size()));

      $display("%0d pixels sent, %0d checked: gray, all sectors, full hue, over-range",
               pixels_sent, pixels_checked);
      $display("idle and stall phases run; input held back on %0d cycles", input_stalls);
      if (errors == 0)
         $display("hsv_to_rgb_converter_unit: match");
      else
         $display("hsv_to_rgb_converter_unit: mismatch");
      $finish;
   end

endmodule

>>> files.f
design/hsvrgb_pkg.sv
design/hsvrgb_sector_mux.sv
design/hsv_to_rgb_converter_unit.sv
design/hsvrgb_checker.sv
tb/tb_hsv_to_rgb_converter_unit.sv
